// ===== src/lspn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lspn_pkg;

    // Field and state widths
    localparam int MAX_POINTS = 64;
    localparam int CNT_W      = 7;
    localparam int POS_W      = 24;
    localparam int PROD_W     = 2 * POS_W;
    localparam int S1_W       = 30;
    localparam int S2_W       = 54;
    localparam int OUT_W      = 32;
    localparam int STAT_W     = 2;

    // Fit arithmetic widths
    localparam int COEF_W     = 61;
    localparam int HALF_W     = 32;
    localparam int PP_W       = 2 * HALF_W;
    localparam int WIDE_W     = 123;
    localparam int KEEP_BITS  = 31;
    localparam int FRAC_BITS  = 30;
    localparam int NORM_COARSE = 16;
    localparam int SQ_W       = 64;
    localparam int LEN_W      = 32;
    localparam int NUM_W      = KEEP_BITS + FRAC_BITS + 1;
    localparam int QUO_W      = 31;
    localparam int NCOEF      = 5;
    localparam int NLANE      = 3;

    // Sequencer step counter and its end points
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] COEF_LAST = STEP_W'(NCOEF - 1);
    localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(23);
    localparam logic [STEP_W-1:0] SQ_FIRST  = STEP_W'(24);
    localparam logic [STEP_W-1:0] SQ_MID    = STEP_W'(25);
    localparam logic [STEP_W-1:0] SQ_LAST   = STEP_W'(26);
    localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(SQ_W / 2 - 1);
    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(QUO_W - 1);

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_SING = 2'd1;
    localparam logic [STAT_W-1:0] ST_FEW  = 2'd2;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic              coef_issue;
        logic [2:0]        coef_sel;
        logic              mag_load;
        logic              mul_issue;
        logic [STEP_W-1:0] mul_idx;
        logic              pqr_load;
        logic              norm_step;
        logic              sqrt_init;
        logic              sqrt_step;
        logic              div_init;
        logic              div_step;
        logic              out_load;
        logic [STAT_W-1:0] out_status;
        logic              clear;
    } cmd_t;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic count_lt3;
        logic q_zero;
        logic norm_done;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== src/lspn_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lspn_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_accept,
    input  logic            last_point,
    input  lspn_pkg::sts_t  sts,
    output logic            in_ready,
    output lspn_pkg::cmd_t  cmd
);
    import lspn_pkg::*;

    localparam logic [3:0] S_ACC   = 4'd0;
    localparam logic [3:0] S_DRAIN = 4'd1;
    localparam logic [3:0] S_COEF  = 4'd2;
    localparam logic [3:0] S_COEFW = 4'd3;
    localparam logic [3:0] S_MAG   = 4'd4;
    localparam logic [3:0] S_PROD  = 4'd5;
    localparam logic [3:0] S_PRODW = 4'd6;
    localparam logic [3:0] S_ZCHK  = 4'd7;
    localparam logic [3:0] S_NORM  = 4'd8;
    localparam logic [3:0] S_SQ    = 4'd9;
    localparam logic [3:0] S_SQW   = 4'd10;
    localparam logic [3:0] S_SINIT = 4'd11;
    localparam logic [3:0] S_SQRT  = 4'd12;
    localparam logic [3:0] S_DINIT = 4'd13;
    localparam logic [3:0] S_DIV   = 4'd14;
    localparam logic [3:0] S_WRITE = 4'd15;

    logic [3:0]        state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [STAT_W-1:0] status_reg, status_next;

    // Sequence the fit one phase after another
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        status_next = status_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        case (state_reg)
            S_ACC:
            begin
                in_ready = 1'b1;
                if (in_accept && last_point)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                cnt_next = '0;
                if (sts.count_lt3)
                begin
                    status_next = ST_FEW;
                    state_next  = S_WRITE;
                end
                else
                begin
                    status_next = ST_OK;
                    state_next  = S_COEF;
                end
            end
            S_COEF:
            begin
                cmd.coef_issue = 1'b1;
                cmd.coef_sel   = cnt_reg[2:0];
                if (cnt_reg == COEF_LAST)
                begin
                    state_next = S_COEFW;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_COEFW:
            begin
                state_next = S_MAG;
            end
            S_MAG:
            begin
                cmd.mag_load = 1'b1;
                cnt_next     = '0;
                state_next   = S_PROD;
            end
            S_PROD:
            begin
                cmd.mul_issue = 1'b1;
                cmd.mul_idx   = cnt_reg;
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = S_PRODW;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_PRODW:
            begin
                state_next = S_ZCHK;
            end
            S_ZCHK:
            begin
                if (sts.q_zero)
                begin
                    status_next = ST_SING;
                    state_next  = S_WRITE;
                end
                else
                begin
                    cmd.pqr_load = 1'b1;
                    state_next   = S_NORM;
                end
            end
            S_NORM:
            begin
                if (sts.norm_done)
                begin
                    cnt_next   = SQ_FIRST;
                    state_next = S_SQ;
                end
                else
                begin
                    cmd.norm_step = 1'b1;
                end
            end
            S_SQ:
            begin
                cmd.mul_issue = 1'b1;
                cmd.mul_idx   = cnt_reg;
                if (cnt_reg == SQ_LAST)
                begin
                    state_next = S_SQW;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_SQW:
            begin
                state_next = S_SINIT;
            end
            S_SINIT:
            begin
                cmd.sqrt_init = 1'b1;
                cnt_next      = '0;
                state_next    = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (cnt_reg == SQRT_LAST)
                begin
                    state_next = S_DINIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_WRITE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = status_reg;
                    cmd.clear      = 1'b1;
                    state_next     = S_ACC;
                end
            end
            default:
            begin
                state_next = S_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_ACC;
            cnt_reg    <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            status_reg <= status_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/lspn_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lspn_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_accept,
    input  logic signed [lspn_pkg::POS_W-1:0]   pos_x,
    input  logic signed [lspn_pkg::POS_W-1:0]   pos_y,
    input  logic signed [lspn_pkg::POS_W-1:0]   pos_z,
    input  lspn_pkg::cmd_t                      cmd,
    output lspn_pkg::sts_t                      sts,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic signed [lspn_pkg::OUT_W-1:0]   normal_x,
    output logic signed [lspn_pkg::OUT_W-1:0]   normal_y,
    output logic signed [lspn_pkg::OUT_W-1:0]   normal_z,
    output logic [lspn_pkg::STAT_W-1:0]         status
);
    import lspn_pkg::*;

    // ---------------- accumulation ----------------
    logic [CNT_W-1:0]         count_reg;
    logic                     keep_s1_reg;
    logic signed [POS_W-1:0]  x_s1_reg, y_s1_reg, z_s1_reg;
    logic signed [PROD_W-1:0] pxy_s1_reg, pxz_s1_reg, pyz_s1_reg, pxx_s1_reg, pyy_s1_reg;
    logic signed [PROD_W-1:0] pxy_next, pxz_next, pyz_next, pxx_next, pyy_next;
    logic signed [S1_W-1:0]   sum_x_reg, sum_y_reg, sum_z_reg;
    logic signed [S2_W-1:0]   sum_xy_reg, sum_xz_reg, sum_yz_reg, sum_xx_reg, sum_yy_reg;
    logic                     room;

    assign room     = count_reg < CNT_W'(MAX_POINTS);
    assign pxy_next = pos_x * pos_y;
    assign pxz_next = pos_x * pos_z;
    assign pyz_next = pos_y * pos_z;
    assign pxx_next = pos_x * pos_x;
    assign pyy_next = pos_y * pos_y;

    // Register the point and its products on each accepted beat
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            x_s1_reg   <= pos_x;
            y_s1_reg   <= pos_y;
            z_s1_reg   <= pos_z;
            pxy_s1_reg <= pxy_next;
            pxz_s1_reg <= pxz_next;
            pyz_s1_reg <= pyz_next;
            pxx_s1_reg <= pxx_next;
            pyy_s1_reg <= pyy_next;
        end
    end

    // Count kept points and add them into the sums in the following cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            keep_s1_reg <= 1'b0;
            sum_x_reg   <= '0;
            sum_y_reg   <= '0;
            sum_z_reg   <= '0;
            sum_xy_reg  <= '0;
            sum_xz_reg  <= '0;
            sum_yz_reg  <= '0;
            sum_xx_reg  <= '0;
            sum_yy_reg  <= '0;
        end
        else
        begin
            keep_s1_reg <= in_accept && room;
            if (cmd.clear)
            begin
                count_reg  <= '0;
                sum_x_reg  <= '0;
                sum_y_reg  <= '0;
                sum_z_reg  <= '0;
                sum_xy_reg <= '0;
                sum_xz_reg <= '0;
                sum_yz_reg <= '0;
                sum_xx_reg <= '0;
                sum_yy_reg <= '0;
            end
            else
            begin
                if (in_accept && room)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                if (keep_s1_reg)
                begin
                    sum_x_reg  <= sum_x_reg + {{(S1_W-POS_W){x_s1_reg[POS_W-1]}}, x_s1_reg};
                    sum_y_reg  <= sum_y_reg + {{(S1_W-POS_W){y_s1_reg[POS_W-1]}}, y_s1_reg};
                    sum_z_reg  <= sum_z_reg + {{(S1_W-POS_W){z_s1_reg[POS_W-1]}}, z_s1_reg};
                    sum_xy_reg <= sum_xy_reg
                                  + {{(S2_W-PROD_W){pxy_s1_reg[PROD_W-1]}}, pxy_s1_reg};
                    sum_xz_reg <= sum_xz_reg
                                  + {{(S2_W-PROD_W){pxz_s1_reg[PROD_W-1]}}, pxz_s1_reg};
                    sum_yz_reg <= sum_yz_reg
                                  + {{(S2_W-PROD_W){pyz_s1_reg[PROD_W-1]}}, pyz_s1_reg};
                    sum_xx_reg <= sum_xx_reg
                                  + {{(S2_W-PROD_W){pxx_s1_reg[PROD_W-1]}}, pxx_s1_reg};
                    sum_yy_reg <= sum_yy_reg
                                  + {{(S2_W-PROD_W){pyy_s1_reg[PROD_W-1]}}, pyy_s1_reg};
                end
            end
        end
    end

    assign sts.count_lt3 = count_reg < CNT_W'(3);

    // ---------------- centered moments A..E ----------------
    logic signed [S2_W-1:0]        csel_n;
    logic signed [S1_W-1:0]        csel_a, csel_b;
    logic signed [CNT_W+S2_W:0]    cn_full;
    logic signed [2*S1_W-1:0]      cs_full;
    logic [COEF_W-1:0]             cn_reg;
    logic [2*S1_W-1:0]             cs_reg;
    logic [2:0]                    cdest_reg;
    logic                          cvalid_reg;
    logic [COEF_W-1:0]             coef_reg [NCOEF];

    // Pick the sums for one moment: n*Sab - Sa*Sb
    always_comb
    begin
        case (cmd.coef_sel)
            3'd1:
            begin
                csel_n = sum_yy_reg;
                csel_a = sum_y_reg;
                csel_b = sum_y_reg;
            end
            3'd2:
            begin
                csel_n = sum_xy_reg;
                csel_a = sum_x_reg;
                csel_b = sum_y_reg;
            end
            3'd3:
            begin
                csel_n = sum_xz_reg;
                csel_a = sum_x_reg;
                csel_b = sum_z_reg;
            end
            3'd4:
            begin
                csel_n = sum_yz_reg;
                csel_a = sum_y_reg;
                csel_b = sum_z_reg;
            end
            default:
            begin
                csel_n = sum_xx_reg;
                csel_a = sum_x_reg;
                csel_b = sum_x_reg;
            end
        endcase
    end

    assign cn_full = $signed({1'b0, count_reg}) * csel_n;
    assign cs_full = csel_a * csel_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cvalid_reg <= 1'b0;
        end
        else
        begin
            cvalid_reg <= cmd.coef_issue;
        end
    end

    // Register both products, then take the difference
    always_ff @(posedge clk)
    begin
        if (cmd.coef_issue)
        begin
            cn_reg    <= cn_full[COEF_W-1:0];
            cs_reg    <= cs_full;
            cdest_reg <= cmd.coef_sel;
        end
        if (cvalid_reg)
        begin
            coef_reg[cdest_reg] <= cn_reg
                                   - {{(COEF_W-2*S1_W){cs_reg[2*S1_W-1]}}, cs_reg};
        end
    end

    // ---------------- magnitudes of A..E ----------------
    logic [COEF_W-1:0] mag_reg [NCOEF];
    logic [NCOEF-1:0]  neg_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mag_load)
        begin
            for (int i = 0; i < NCOEF; i++)
            begin
                neg_reg[i] <= coef_reg[i][COEF_W-1];
                mag_reg[i] <= coef_reg[i][COEF_W-1] ? (COEF_W'(0) - coef_reg[i])
                                                    : coef_reg[i];
            end
        end
    end

    // ---------------- shared 32x32 multiplier ----------------
    logic [WIDE_W-1:0] nrm_reg [NLANE];
    logic [COEF_W-1:0] opa_full, opb_full;
    logic              opa_neg, opb_neg, op_sub;
    logic [2:0]        prod_sel;
    logic [1:0]        part_sel;
    logic [HALF_W-1:0] ma, mb;
    logic [1:0]        sh_next, dest_next;
    logic              first_next, final_next, neg_next;
    logic [PP_W-1:0]   pp_reg;
    logic [1:0]        pp_sh_reg, pp_dest_reg;
    logic              pp_first_reg, pp_final_reg, pp_neg_reg, pp_valid_reg;

    // Select the partial product for this step
    always_comb
    begin
        prod_sel = cmd.mul_idx[4:2];
        part_sel = cmd.mul_idx[1:0];
        case (prod_sel)
            3'd1:
            begin
                opa_full = mag_reg[2];
                opb_full = mag_reg[2];
                opa_neg  = neg_reg[2];
                opb_neg  = neg_reg[2];
                op_sub   = 1'b1;
            end
            3'd2:
            begin
                opa_full = mag_reg[4];
                opb_full = mag_reg[2];
                opa_neg  = neg_reg[4];
                opb_neg  = neg_reg[2];
                op_sub   = 1'b0;
            end
            3'd3:
            begin
                opa_full = mag_reg[3];
                opb_full = mag_reg[1];
                opa_neg  = neg_reg[3];
                opb_neg  = neg_reg[1];
                op_sub   = 1'b1;
            end
            3'd4:
            begin
                opa_full = mag_reg[3];
                opb_full = mag_reg[2];
                opa_neg  = neg_reg[3];
                opb_neg  = neg_reg[2];
                op_sub   = 1'b0;
            end
            3'd5:
            begin
                opa_full = mag_reg[4];
                opb_full = mag_reg[0];
                opa_neg  = neg_reg[4];
                opb_neg  = neg_reg[0];
                op_sub   = 1'b1;
            end
            default:
            begin
                opa_full = mag_reg[0];
                opb_full = mag_reg[1];
                opa_neg  = neg_reg[0];
                opb_neg  = neg_reg[1];
                op_sub   = 1'b0;
            end
        endcase
        ma = part_sel[1] ? {{(2*HALF_W-COEF_W){1'b0}}, opa_full[COEF_W-1:HALF_W]}
                         : opa_full[HALF_W-1:0];
        mb = part_sel[0] ? {{(2*HALF_W-COEF_W){1'b0}}, opb_full[COEF_W-1:HALF_W]}
                         : opb_full[HALF_W-1:0];
        sh_next    = {1'b0, part_sel[1]} + {1'b0, part_sel[0]};
        first_next = !prod_sel[0] && (part_sel == 2'b00);
        final_next = prod_sel[0] && (part_sel == 2'b11);
        dest_next  = prod_sel[2:1];
        neg_next   = opa_neg ^ opb_neg ^ op_sub;
        // Squares of the normalized components
        if (cmd.mul_idx == SQ_FIRST || cmd.mul_idx == SQ_MID || cmd.mul_idx == SQ_LAST)
        begin
            if (cmd.mul_idx == SQ_FIRST)
            begin
                ma = {{(HALF_W-KEEP_BITS){1'b0}}, nrm_reg[0][KEEP_BITS-1:0]};
            end
            else if (cmd.mul_idx == SQ_MID)
            begin
                ma = {{(HALF_W-KEEP_BITS){1'b0}}, nrm_reg[1][KEEP_BITS-1:0]};
            end
            else
            begin
                ma = {{(HALF_W-KEEP_BITS){1'b0}}, nrm_reg[2][KEEP_BITS-1:0]};
            end
            mb         = ma;
            sh_next    = 2'd0;
            first_next = cmd.mul_idx == SQ_FIRST;
            final_next = 1'b0;
            dest_next  = 2'd3;
            neg_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pp_valid_reg <= 1'b0;
        end
        else
        begin
            pp_valid_reg <= cmd.mul_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_issue)
        begin
            pp_reg       <= ma * mb;
            pp_sh_reg    <= sh_next;
            pp_first_reg <= first_next;
            pp_final_reg <= final_next;
            pp_dest_reg  <= dest_next;
            pp_neg_reg   <= neg_next;
        end
    end

    // ---------------- wide accumulator: Q, P, R and S ----------------
    logic [WIDE_W-1:0] term, acc_base, acc_next, acc_reg;
    logic [WIDE_W-1:0] qpr_reg [NLANE];

    always_comb
    begin
        term     = {{(WIDE_W-PP_W){1'b0}}, pp_reg} << {pp_sh_reg, 5'b0};
        acc_base = pp_first_reg ? '0 : acc_reg;
        acc_next = pp_neg_reg ? (acc_base - term) : (acc_base + term);
    end

    always_ff @(posedge clk)
    begin
        if (pp_valid_reg)
        begin
            acc_reg <= acc_next;
            if (pp_final_reg && pp_dest_reg != 2'd3)
            begin
                qpr_reg[pp_dest_reg] <= acc_next;
            end
        end
    end

    assign sts.q_zero = qpr_reg[0] == '0;

    // ---------------- normalization ----------------
    logic              pneg_reg, rneg_reg, qneg;
    logic [WIDE_W-1:0] nrm_or;
    logic              big;

    assign qneg      = qpr_reg[0][WIDE_W-1];
    assign nrm_or    = nrm_reg[0] | nrm_reg[1] | nrm_reg[2];
    assign big       = |nrm_or[WIDE_W-1:KEEP_BITS+NORM_COARSE];
    assign sts.norm_done = !(|nrm_or[WIDE_W-1:KEEP_BITS]);

    // Load |P|, |R|, |Q|, then shift right until all fit in 31 bits
    always_ff @(posedge clk)
    begin
        if (cmd.pqr_load)
        begin
            pneg_reg   <= qpr_reg[1][WIDE_W-1] ^ qneg;
            rneg_reg   <= qpr_reg[2][WIDE_W-1] ^ qneg;
            nrm_reg[0] <= qpr_reg[1][WIDE_W-1] ? (WIDE_W'(0) - qpr_reg[1]) : qpr_reg[1];
            nrm_reg[1] <= qpr_reg[2][WIDE_W-1] ? (WIDE_W'(0) - qpr_reg[2]) : qpr_reg[2];
            nrm_reg[2] <= qneg ? (WIDE_W'(0) - qpr_reg[0]) : qpr_reg[0];
        end
        else if (cmd.norm_step)
        begin
            for (int k = 0; k < NLANE; k++)
            begin
                nrm_reg[k] <= big ? (nrm_reg[k] >> NORM_COARSE) : (nrm_reg[k] >> 1);
            end
        end
    end

    // ---------------- integer square root, one result bit a cycle ----------------
    logic [SQ_W-1:0] srem_reg, sres_reg, sbit_reg, strial;
    logic            sge;

    assign strial = sres_reg | sbit_reg;
    assign sge    = srem_reg >= strial;

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_init)
        begin
            srem_reg <= acc_reg[SQ_W-1:0];
            sres_reg <= '0;
            sbit_reg <= SQ_W'(1) << (SQ_W - 2);
        end
        else if (cmd.sqrt_step)
        begin
            if (sge)
            begin
                srem_reg <= srem_reg - strial;
                sres_reg <= (sres_reg >> 1) + sbit_reg;
            end
            else
            begin
                sres_reg <= sres_reg >> 1;
            end
            sbit_reg <= sbit_reg >> 2;
        end
    end

    // ---------------- three restoring dividers ----------------
    logic [LEN_W-1:0]     len;
    logic [NUM_W-1:0]     num    [NLANE];
    logic [LEN_W:0]       dtrial [NLANE];
    logic [NLANE-1:0]     dge;
    logic [LEN_W-1:0]     drem_reg [NLANE];
    logic [QUO_W-1:0]     dlow_reg [NLANE];
    logic [QUO_W-1:0]     quo_reg  [NLANE];

    assign len = sres_reg[LEN_W-1:0];

    // Round half up: divide (mag * 2^30 + len/2) by len
    always_comb
    begin
        for (int k = 0; k < NLANE; k++)
        begin
            num[k]    = {1'b0, nrm_reg[k][KEEP_BITS-1:0], {FRAC_BITS{1'b0}}}
                        + {{(NUM_W-LEN_W+1){1'b0}}, len[LEN_W-1:1]};
            dtrial[k] = {drem_reg[k], dlow_reg[k][QUO_W-1]};
            dge[k]    = dtrial[k] >= {1'b0, len};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NLANE; k++)
        begin
            if (cmd.div_init)
            begin
                drem_reg[k] <= {{(LEN_W-(NUM_W-QUO_W)){1'b0}}, num[k][NUM_W-1:QUO_W]};
                dlow_reg[k] <= num[k][QUO_W-1:0];
                quo_reg[k]  <= '0;
            end
            else if (cmd.div_step)
            begin
                drem_reg[k] <= dge[k] ? LEN_W'(dtrial[k] - {1'b0, len})
                                      : dtrial[k][LEN_W-1:0];
                dlow_reg[k] <= dlow_reg[k] << 1;
                quo_reg[k]  <= {quo_reg[k][QUO_W-2:0], dge[k]};
            end
        end
    end

    // ---------------- output register ----------------
    logic                     out_valid_reg;
    logic [OUT_W-1:0]         nx_reg, ny_reg, nz_reg;
    logic [STAT_W-1:0]        stat_reg;
    logic [OUT_W-1:0]         comp_x, comp_y, comp_z;
    logic                     zero_out;

    assign sts.out_free = !out_valid_reg || out_ready;
    assign zero_out     = cmd.out_status != ST_OK;
    assign comp_x = pneg_reg ? (OUT_W'(0) - {1'b0, quo_reg[0]}) : {1'b0, quo_reg[0]};
    assign comp_y = rneg_reg ? (OUT_W'(0) - {1'b0, quo_reg[1]}) : {1'b0, quo_reg[1]};
    assign comp_z = {1'b0, quo_reg[2]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            nx_reg   <= zero_out ? '0 : comp_x;
            ny_reg   <= zero_out ? '0 : comp_y;
            nz_reg   <= zero_out ? '0 : comp_z;
            stat_reg <= cmd.out_status;
        end
    end

    assign out_valid = out_valid_reg;
    assign normal_x  = nx_reg;
    assign normal_y  = ny_reg;
    assign normal_z  = nz_reg;
    assign status    = stat_reg;

endmodule

`default_nettype wire

// ===== src/least_squares_plane_normal_core.sv =====
// After the beat marked last_point the core runs the fit and then presents the result
// beat, which waits on any output stall; a zero determinant or fewer than three points
// skip the rest. The normalizing shift loop (0 to 20 steps), the 32-step square root and
// the 31-step dividers set the fit time. Accepts one point per cycle while a run
// accumulates; no beat is taken while a fit runs. Throughput: one result per run of points.
// Reset (rst_n low, asynchronous) clears the count, all sums and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module least_squares_plane_normal_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [lspn_pkg::POS_W-1:0]   pos_x,
    input  logic signed [lspn_pkg::POS_W-1:0]   pos_y,
    input  logic signed [lspn_pkg::POS_W-1:0]   pos_z,
    input  logic                                last_point,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [lspn_pkg::OUT_W-1:0]   normal_x,
    output logic signed [lspn_pkg::OUT_W-1:0]   normal_y,
    output logic signed [lspn_pkg::OUT_W-1:0]   normal_z,
    output logic [lspn_pkg::STAT_W-1:0]         status
);
    import lspn_pkg::*;

    logic in_accept;
    cmd_t cmd;
    sts_t sts;

    assign in_accept = in_valid && in_ready;

    lspn_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_accept  (in_accept),
        .last_point (last_point),
        .sts        (sts),
        .in_ready   (in_ready),
        .cmd        (cmd)
    );

    lspn_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .normal_x  (normal_x),
        .normal_y  (normal_y),
        .normal_z  (normal_z),
        .status    (status)
    );

    // A failed fit carries a zero normal
    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
        else $error("nonzero normal with failing status");

    // The z component of the normal is never negative
    a_z_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !normal_z[OUT_W-1])
        else $error("negative normal_z");

    // The last point of a run stops intake while the fit runs
    a_stop_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_point |=> !in_ready)
        else $error("intake open after last point");

endmodule

`default_nettype wire
